### design/slrd_pkg.sv
// slrd_pkg: shared types and constants for the skip/literal RLE decoder.
// Used by slrd_decode and skip_literal_rle_decoder; no dependencies.
`timescale 1ns / 1ps

package slrd_pkg;

	localparam int COUNT_WIDTH = 24;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERRUN   = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	typedef struct packed {
		logic        emit;
		logic [7:0]  pixel_value;
		logic [7:0]  run_length;
		logic        end_of_cell;
		status_t     status;
		logic [23:0] fill_count;
	} result_t;

endpackage

### design/skip_literal_rle_decoder.sv
// skip_literal_rle_decoder: top level, input register, result register, config.
// Depends on slrd_pkg and slrd_decode.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_stall  data_byte, last_byte
//   out      result     out_valid / out_stall pixel_value, run_length, end_of_cell,
//                                            status, fill_count
//   cfg      write      cfg_write            pixel_total
//
// One byte per cycle sustained while out_stall does not hold the pipe; a byte passes
// through the input register, then the result register. Rate is set by the cell-state update in slrd_decode.
// Reset clears pipeline valids, cell state and pixel_total.
// An out stall holds the result register and the input register behind it.
`timescale 1ns / 1ps

module skip_literal_rle_decoder import slrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [23:0] pixel_total,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pixel_value,
	output logic [7:0]  run_length,
	output logic        end_of_cell,
	output logic [1:0]  status,
	output logic [23:0] fill_count
);

	logic [23:0] pixel_total_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	result_t     out_q;
	result_t     res;
	logic        adv;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_total_q <= 24'd0;
		else if (cfg_write)
			pixel_total_q <= pixel_total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	slrd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.pixel_total (pixel_total_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = out_q.pixel_value;
	assign run_length  = out_q.run_length;
	assign end_of_cell = out_q.end_of_cell;
	assign status      = out_q.status;
	assign fill_count  = out_q.fill_count;

endmodule

### design/slrd_decode.sv
// slrd_decode: per-cell decode state and next-state logic, one byte a cycle when fire is high.
// Depends on slrd_pkg.
`timescale 1ns / 1ps

module slrd_decode import slrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [23:0] pixel_total,
	output result_t     res
);

	logic       in_lit_q;
	logic [7:0] lit_left_q;
	cnt_t       written_q;
	logic       stopped_q;
	status_t    err_q;

	logic       in_lit_n;
	logic [7:0] lit_left_n;
	cnt_t       written_n;
	logic       stopped_n;
	status_t    err_n;

	cnt_t       total;
	cnt_t       rem;
	logic       rem_zero;
	logic       skip;
	logic [7:0] count;
	logic [7:0] rl;
	logic [7:0] pv;
	logic       emit;

	assign total    = COUNT_WIDTH'(pixel_total);
	assign rem      = (total > written_q) ? (total - written_q) : '0;
	assign rem_zero = (rem == '0);
	assign skip     = data_byte[7];
	assign count    = skip ? (~data_byte + 8'd1) : (data_byte + 8'd1);

	always_comb begin
		in_lit_n   = in_lit_q;
		lit_left_n = lit_left_q;
		written_n  = written_q;
		stopped_n  = stopped_q;
		err_n      = err_q;
		pv         = 8'd0;
		rl         = 8'd0;
		emit       = 1'b0;
		if (!stopped_q) begin
			if (in_lit_q) begin
				if (rem_zero) begin
					in_lit_n   = 1'b0;
					lit_left_n = 8'd0;
					stopped_n  = 1'b1;
				end else begin
					pv         = data_byte;
					rl         = 8'd1;
					emit       = 1'b1;
					written_n  = written_q + cnt_t'(1);
					lit_left_n = lit_left_q - 8'd1;
					if (lit_left_n == 8'd0)
						in_lit_n = 1'b0;
				end
			end else if (rem_zero) begin
				stopped_n = 1'b1;
			end else if (COUNT_WIDTH'(count) > rem) begin
				err_n     = ST_OVERRUN;
				stopped_n = 1'b1;
			end else if (skip) begin
				rl        = count;
				emit      = 1'b1;
				written_n = written_q + COUNT_WIDTH'(count);
			end else begin
				in_lit_n   = 1'b1;
				lit_left_n = count;
			end
			if (!stopped_n && !in_lit_n && (rem == COUNT_WIDTH'(rl)))
				stopped_n = 1'b1;
		end
	end

	always_comb begin
		res.emit        = emit || last_byte;
		res.pixel_value = pv;
		res.run_length  = rl;
		res.end_of_cell = last_byte;
		res.status      = ST_OK;
		res.fill_count  = 24'd0;
		if (last_byte) begin
			priority if (err_n != ST_OK)
				res.status = err_n;
			else if (in_lit_n && (lit_left_n != 8'd0))
				res.status = ST_TRUNCATED;
			else
				res.status = ST_OK;
			res.fill_count = 24'(rem - COUNT_WIDTH'(rl));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lit_q   <= 1'b0;
			lit_left_q <= 8'd0;
			written_q  <= '0;
			stopped_q  <= 1'b0;
			err_q      <= ST_OK;
		end else if (fire) begin
			if (last_byte) begin
				in_lit_q   <= 1'b0;
				lit_left_q <= 8'd0;
				written_q  <= '0;
				stopped_q  <= 1'b0;
				err_q      <= ST_OK;
			end else begin
				in_lit_q   <= in_lit_n;
				lit_left_q <= lit_left_n;
				written_q  <= written_n;
				stopped_q  <= stopped_n;
				err_q      <= err_n;
			end
		end
	end

endmodule
